/* rtl/core/assert_macros.svh */
// assertion helper macros used by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");

`endif

/* rtl/core/tkws_pkg.sv */
// shared types and constants of the top-k weight selector
// no dependencies
package tkws_pkg;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEEP_W       = 7;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned DOC_W        = 32;
  localparam int unsigned OBJ_W        = 64;
  localparam int unsigned TAG_W        = 32;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  localparam logic [1:0] MODE_OFFER   = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // one stored posting
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [TAG_W-1:0]    tag;
    logic [DOC_W-1:0]    doc;
    logic [OBJ_W-1:0]    obj;
  } entry_t;

  // true when a ranks strictly above b
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.weight != b.weight) r = a.weight > b.weight;
    else r = a.tag < b.tag;
    return r;
  endfunction
endpackage

/* rtl/core/tkws_store.sv */
// entry memory of the top-k weight selector, one write and one read port
// depends on tkws_pkg
module tkws_store #(
  parameter int unsigned CAPACITY = tkws_pkg::CAPACITY_DEF,
  parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  tkws_pkg::entry_t      wdata,
  input  logic [AW-1:0]         raddr,
  output tkws_pkg::entry_t      rdata
);
  tkws_pkg::entry_t mem [CAPACITY];

  // synchronous write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/top_k_weight_selector.sv */
// Top-k weight selector: keeps the keep_count highest-weighted postings in a
// memory of CAPACITY entries. An offer while not full, a clear and an unused
// mode are handled in the idle state. An offer when full scans all stored
// entries through the single memory read port. An extract runs the scan, a
// step that fetches the last entry, a step that moves it into the freed slot
// and the result step that loads the result. An extract on an empty store
// goes straight to the result step. One item is processed at a time. The
// result word sits in an output register, so the next item can be taken
// while it waits; a later extract holds in its result step until that
// register is free.
// Depends on tkws_pkg, tkws_store and assert_macros.svh.
`include "assert_macros.svh"
module top_k_weight_selector #(
  parameter int unsigned CAPACITY = tkws_pkg::CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], weight[33:2], logical_doc_id[65:34], object_id[129:66], zero pad
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_weight[31:0], out_doc_id[63:32], out_object_id[127:64], end_of_results[128]
  output logic [135:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_DONE, S_MOVE, S_RESULT
  } state_t;

  state_t state_r;
  logic [tkws_pkg::KEEP_W-1:0] keep_r;
  logic [CW-1:0] fill_r;
  logic [tkws_pkg::TAG_W-1:0] arr_r;
  logic [1:0] mode_r;
  tkws_pkg::entry_t in_e_r, best_r, rd;
  logic [AW-1:0] best_idx_r, rd_idx_r, scan_r;
  logic [CW-1:0] issued_r;
  logic rd_v_r, first_r;
  logic eor_r;
  logic out_v_r;
  logic [135:0] out_d_r;
  logic res_load;

  logic we;
  logic [AW-1:0] waddr, raddr;
  tkws_pkg::entry_t wdata;

  logic [CW-1:0] limit;
  assign limit = ({25'd0, keep_r} > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(keep_r);

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  // result step loads the output register once it is free
  assign res_load = (state_r == S_RESULT) && (!out_v_r || out_tready);

  tkws_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  // read address follows the scan counter or the last entry for a move
  always_comb begin
    raddr = scan_r;
    if (state_r == S_DONE) raddr = AW'(fill_r - CW'(1));
  end

  // write port: direct insert, replacement of min, or hole fill on extract
  always_comb begin
    we = 1'b0;
    waddr = best_idx_r;
    wdata = in_e_r;
    wdata.tag = arr_r;
    if (state_r == S_IDLE && in_tvalid && in_tready &&
        in_tdata[1:0] == tkws_pkg::MODE_OFFER && CW'(0) + fill_r < limit) begin
      we = 1'b1;
      waddr = AW'(fill_r);
      wdata.weight = in_tdata[33:2];
      wdata.doc = in_tdata[65:34];
      wdata.obj = in_tdata[129:66];
    end else if (state_r == S_DONE && mode_r == tkws_pkg::MODE_OFFER &&
                 in_e_r.weight > best_r.weight) begin
      we = 1'b1;
    end else if (state_r == S_MOVE) begin
      we = 1'b1;
      wdata = rd;
    end
  end

  // control, scan and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      keep_r <= tkws_pkg::KEEP_RESET;
      fill_r <= '0;
      arr_r <= '0;
      out_v_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      if (cfg_valid) keep_r <= cfg_data;
      out_v_r <= res_load || (out_v_r && !out_tready);
      if (we && !(state_r == S_MOVE)) arr_r <= arr_r + 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r <= in_tdata[1:0];
            in_e_r.weight <= in_tdata[33:2];
            in_e_r.tag <= '0;
            in_e_r.doc <= in_tdata[65:34];
            in_e_r.obj <= in_tdata[129:66];
            scan_r <= '0;
            issued_r <= '0;
            first_r <= 1'b1;
            rd_v_r <= 1'b0;
            case (in_tdata[1:0])
              tkws_pkg::MODE_OFFER: begin
                if (fill_r < limit) fill_r <= fill_r + CW'(1);
                else if (fill_r != '0 && limit != '0) state_r <= S_SCAN;
              end
              tkws_pkg::MODE_EXTRACT: begin
                if (fill_r == '0) begin
                  eor_r <= 1'b1;
                  state_r <= S_RESULT;
                end else begin
                  eor_r <= 1'b0;
                  state_r <= S_SCAN;
                end
              end
              tkws_pkg::MODE_CLEAR: begin
                fill_r <= '0;
                arr_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN, S_WAIT: begin
          // issue reads while entries remain, compare registered data
          if (state_r == S_SCAN) begin
            rd_idx_r <= scan_r;
            rd_v_r <= 1'b1;
            issued_r <= issued_r + CW'(1);
            scan_r <= scan_r + AW'(1);
            if (issued_r + CW'(1) == fill_r) state_r <= S_WAIT;
          end else begin
            rd_v_r <= 1'b0;
            state_r <= S_DONE;
          end
          if (rd_v_r) begin
            first_r <= 1'b0;
            if (first_r ||
                (mode_r == tkws_pkg::MODE_EXTRACT && tkws_pkg::ranks_above(rd, best_r)) ||
                (mode_r == tkws_pkg::MODE_OFFER && tkws_pkg::ranks_above(best_r, rd))) begin
              best_r <= rd;
              best_idx_r <= rd_idx_r;
            end
          end
        end
        S_DONE: begin
          if (mode_r == tkws_pkg::MODE_OFFER) state_r <= S_IDLE;
          else state_r <= S_MOVE;
        end
        S_MOVE: begin
          fill_r <= fill_r - CW'(1);
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          // hold until the previous word has left the output register
          if (res_load) begin
            if (eor_r) out_d_r <= {7'd0, 1'b1, 128'd0};
            else out_d_r <= {7'd0, 1'b0, best_r.obj, best_r.doc, best_r.weight};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fill never exceeds capacity
  `ASSERT_ALWAYS(a_fill_cap, clk, rst_n, fill_r <= CW'(CAPACITY))
  // a result is only raised from the result step
  `ASSERT_NEXT(a_out_src, clk, rst_n, !out_v_r && state_r != S_RESULT, !out_v_r)
  // input is never taken while a scan runs
  `ASSERT_ALWAYS(a_no_take, clk, rst_n, !(in_tready && state_r != S_IDLE))
endmodule
